// ----- hw/rtl/sfr_pkg.sv -----
// Shared types, register indexes and helpers for the stream find-and-replace unit.
// Used by sfr_cfg and stream_find_and_replace_unit; depends on nothing else.
`default_nettype none

package sfr_pkg;

  // Default sizes of the window and of the replacement string.
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // Number of bytes held in a packed 64-bit string register.
  localparam int PACKED_BYTES = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
  } cfg_regs_t;

  // Byte k of a packed string; bytes past the eighth read as zero.
  function automatic logic [7:0] packed_byte(input logic [63:0] packed_str,
                                             input int unsigned k);
    logic [7:0] b;
    b = 8'h00;
    if (k < PACKED_BYTES) begin
      b = packed_str[8*k +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sfr_cfg.sv -----
// Configuration register file of the stream find-and-replace unit.
// Depends on sfr_pkg for the register indexes and the register struct.
`default_nettype none

module sfr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           window_empty,
  output sfr_pkg::cfg_regs_t                  cfg_regs
);
  import sfr_pkg::*;

  cfg_regs_t regs_r;

  // The pattern length can only change while the window holds no bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pattern_bytes      <= '0;
      regs_r.pattern_length     <= 4'd1;
      regs_r.replacement_bytes  <= '0;
      regs_r.replacement_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES: begin
          regs_r.pattern_bytes <= cfg_data[63:0];
        end
        CFG_PATTERN_LENGTH: begin
          if (window_empty) begin
            regs_r.pattern_length <= cfg_data[3:0];
          end
        end
        CFG_REPLACEMENT_BYTES: begin
          regs_r.replacement_bytes <= cfg_data[63:0];
        end
        CFG_REPLACEMENT_LENGTH: begin
          regs_r.replacement_length <= cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_regs = regs_r;

endmodule

`default_nettype wire

// ----- hw/rtl/stream_find_and_replace_unit.sv -----
// Top level of the stream find-and-replace unit: sequencer, byte window and output register.
// Depends on sfr_pkg and instantiates sfr_cfg.
`default_nettype none

// The unit takes a byte stream on the in_ channel and returns the edited stream on the
// out_ channel, replacing every leftmost, non-overlapping occurrence of the configured
// pattern with the configured replacement. Both channels use valid/ready; one input
// transaction carries an optional byte and an end-of-string flag, and causes zero up to
// max(MAX_REPLACEMENT, MAX_PATTERN) + 1 output transactions. The last output transaction
// caused by an input has run_last set; the zero terminator has string_end set.
//
// Operation: in_ready is high only while the sequencer is idle. Once the window holds
// pattern_length bytes, one shared byte comparator checks one window position per cycle,
// then either the replacement, if not empty, is sent at one byte per cycle while the
// receiver takes them, or the oldest window byte is sent. At end of string the
// remaining window bytes and the terminator go out at one per cycle while the receiver
// takes them. The output register lets a new item be accepted while the previous result
// still waits.
//
// Reset (synchronous, active low) empties the window, clears the output valid flag and
// loads pattern_length 1 with all other registers zero. When the receiver stalls, the
// sequencer holds its position until the output register is free again.
// Configuration writes are expected only while the unit is idle.

module stream_find_and_replace_unit #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire sfr_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      sfr_pkg::out_item_t             out_data,
  input  wire logic                           cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfr_pkg::*;

  // Window count holds 0..MAX_PATTERN; the window index addresses MAX_PATTERN entries.
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int RLEN_W  = $clog2(MAX_REPLACEMENT + 1);
  localparam int WIN_IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int IDX_MAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int IDX_W   = (IDX_MAX > 1) ? $clog2(IDX_MAX) : 1;
  localparam int PEXT_W  = (CNT_W > 4) ? CNT_W : 4;
  localparam int REXT_W  = (RLEN_W > 4) ? RLEN_W : 4;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CMP   = 6'b000010,
    ST_REPL  = 6'b000100,
    ST_EMIT1 = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_TERM  = 6'b100000
  } state_t;

  cfg_regs_t cfg_regs;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              match_r, match_nxt;
  logic              end_r, end_nxt;
  logic [7:0]        win_r [MAX_PATTERN];

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_acc;
  logic              can_emit;
  logic              emit_vld;
  out_item_t         emit_item;
  logic              win_wr;
  logic              win_shift;

  logic [PEXT_W-1:0] plen_ext;
  logic [REXT_W-1:0] rlen_ext;
  logic [CNT_W-1:0]  plen;
  logic [RLEN_W-1:0] rlen;
  logic [IDX_W-1:0]  plen_m1;
  logic [IDX_W-1:0]  rlen_m1;
  logic [IDX_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        win_rd;
  logic              byte_eq;
  logic              match_all;

  sfr_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .window_empty (cnt_r == '0),
    .cfg_regs     (cfg_regs)
  );

  // Effective lengths: an empty pattern counts as one byte, both saturate at the maximum.
  always_comb begin
    plen_ext = PEXT_W'(cfg_regs.pattern_length);
    if (plen_ext == '0) begin
      plen = CNT_W'(1);
    end else if (plen_ext > PEXT_W'(MAX_PATTERN)) begin
      plen = CNT_W'(MAX_PATTERN);
    end else begin
      plen = CNT_W'(plen_ext);
    end
    rlen_ext = REXT_W'(cfg_regs.replacement_length);
    if (rlen_ext > REXT_W'(MAX_REPLACEMENT)) begin
      rlen = RLEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = RLEN_W'(rlen_ext);
    end
  end

  assign plen_m1 = IDX_W'(plen - CNT_W'(1));
  assign rlen_m1 = IDX_W'(rlen - RLEN_W'(1));
  assign cnt_m1  = IDX_W'(cnt_r - CNT_W'(1));
  assign cnt_inc = cnt_r + CNT_W'(1);

  // The indexed window read port and the shared byte comparator, both steered by idx_r.
  assign win_rd    = win_r[idx_r[WIN_IW-1:0]];
  assign byte_eq   = (win_rd == packed_byte(cfg_regs.pattern_bytes, 32'(idx_r)));
  assign match_all = match_r & byte_eq;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    end_nxt   = end_r;
    win_wr    = 1'b0;
    win_shift = 1'b0;
    emit_vld  = 1'b0;
    emit_item = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          end_nxt = in_data.end_of_string;
          idx_nxt = '0;
          if (in_data.byte_valid && (cnt_r < CNT_W'(MAX_PATTERN))) begin
            // Append the byte; a full window goes to the comparator next.
            win_wr  = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= plen) begin
              match_nxt = 1'b1;
              state_nxt = ST_CMP;
            end else if (in_data.end_of_string) begin
              state_nxt = ST_FLUSH;
            end
          end else if (in_data.end_of_string) begin
            state_nxt = (cnt_r == '0) ? ST_TERM : ST_FLUSH;
          end
        end
      end

      ST_CMP: begin
        if (idx_r == plen_m1) begin
          idx_nxt = '0;
          if (match_all) begin
            // The whole window is consumed by the match.
            cnt_nxt = '0;
            if (rlen != '0) begin
              state_nxt = ST_REPL;
            end else begin
              state_nxt = end_r ? ST_TERM : ST_IDLE;
            end
          end else begin
            state_nxt = ST_EMIT1;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          match_nxt = match_all;
        end
      end

      ST_REPL: begin
        emit_vld           = 1'b1;
        emit_item.out_byte = packed_byte(cfg_regs.replacement_bytes, 32'(idx_r));
        emit_item.run_last = (idx_r == rlen_m1) && !end_r;
        if (can_emit) begin
          if (idx_r == rlen_m1) begin
            state_nxt = end_r ? ST_TERM : ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_EMIT1: begin
        emit_vld           = 1'b1;
        emit_item.out_byte = win_r[0];
        emit_item.run_last = !end_r;
        if (can_emit) begin
          win_shift = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          idx_nxt   = '0;
          if (end_r) begin
            state_nxt = (cnt_r == CNT_W'(1)) ? ST_TERM : ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        emit_vld           = 1'b1;
        emit_item.out_byte = win_rd;
        if (can_emit) begin
          if (idx_r == cnt_m1) begin
            cnt_nxt   = '0;
            state_nxt = ST_TERM;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_TERM: begin
        emit_vld             = 1'b1;
        emit_item.out_byte   = 8'h00;
        emit_item.run_last   = 1'b1;
        emit_item.string_end = 1'b1;
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      match_r <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      match_r <= match_nxt;
      end_r   <= end_nxt;
    end
  end

  // The window is payload: entries above the count are never read.
  always_ff @(posedge clk) begin
    if (win_wr) begin
      win_r[cnt_r[WIN_IW-1:0]] <= in_data.data_byte;
    end else if (win_shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
  end

  // Output register decouples the sequencer from a stalling receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_vld && can_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld && can_emit) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // While idle the window never holds a full pattern's worth of bytes.
  a_idle_window_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < plen))
    else $error("window holds a full pattern while idle");

  // A terminator is always the last result of its input.
  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.string_end) |-> out_data_r.run_last)
    else $error("terminator without run_last");

  // While the sequencer sends the terminator the window is already empty.
  a_term_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TERM) |-> (cnt_r == '0))
    else $error("window not empty while sending the terminator");

  // No new input is taken while a replacement or flush is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_vld && !can_emit) |=> !in_ready || $past(state_r == ST_TERM) ||
      $past(state_r == ST_EMIT1) || $past(state_r == ST_REPL))
    else $error("input accepted during a stalled emission");

endmodule

`default_nettype wire
